// File: rtl/arri_pkg.sv
// Shared types and constants for the ray and rectangle intersection block.
package arri_pkg;

    typedef enum logic [1:0] {
        AXIS_XY = 2'd0,
        AXIS_XZ = 2'd1,
        AXIS_YZ = 2'd2,
        AXIS_NONE = 2'd3
    } t_axis;

    localparam logic [2:0] CFG_AXIS_SELECT  = 3'd0;
    localparam logic [2:0] CFG_PLANE_OFFSET = 3'd1;
    localparam logic [2:0] CFG_FIRST_LOW    = 3'd2;
    localparam logic [2:0] CFG_FIRST_HIGH   = 3'd3;
    localparam logic [2:0] CFG_SECOND_LOW   = 3'd4;
    localparam logic [2:0] CFG_SECOND_HIGH  = 3'd5;
    localparam logic [2:0] CFG_MATERIAL_ID  = 3'd6;

    localparam int TEX_BITS = 16;
    localparam int TEX_W    = TEX_BITS + 1;
    localparam int DIV_W    = 32;

    typedef struct packed {
        logic signed [31:0] range_max;
        logic signed [31:0] range_min;
        logic signed [31:0] dir_z;
        logic signed [31:0] dir_y;
        logic signed [31:0] dir_x;
        logic signed [31:0] origin_z;
        logic signed [31:0] origin_y;
        logic signed [31:0] origin_x;
    } t_ray;

    typedef struct packed {
        t_ray ray;
        logic neg;
        logic kill;
    } t_ray_side;

    typedef struct packed {
        logic               hit;
        logic               zero_span;
        logic signed [31:0] t;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
    } t_hit_side;

endpackage

// File: rtl/arri_div_cell.sv
// One restoring division step with its pipeline register and passed sideband.
module arri_div_cell
    import arri_pkg::*;
#(
    parameter int DQ_W   = 17,
    parameter int SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [DIV_W-1:0]  i_rem,
    input  logic [DQ_W-1:0]   i_dq,
    input  logic [DIV_W-1:0]  i_dvs,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [DIV_W-1:0]  o_rem,
    output logic [DQ_W-1:0]   o_dq,
    output logic [DIV_W-1:0]  o_dvs,
    output logic [SIDE_W-1:0] o_side
);

    logic [DIV_W:0]   w_trial;
    logic [DIV_W:0]   w_diff;
    logic             w_ge;
    logic [DIV_W-1:0] n_rem;
    logic [DQ_W-1:0]  n_dq;
    logic             r_valid;
    logic [DIV_W-1:0] r_rem;
    logic [DQ_W-1:0]  r_dq;
    logic [DIV_W-1:0] r_dvs;
    logic [SIDE_W-1:0] r_side;

    always_comb begin
        w_trial = {i_rem, i_dq[DQ_W-1]};
        w_diff  = w_trial - {1'b0, i_dvs};
        w_ge    = (w_trial >= {1'b0, i_dvs});
        n_rem   = w_ge ? w_diff[DIV_W-1:0] : w_trial[DIV_W-1:0];
        n_dq    = {i_dq[DQ_W-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_dq   <= n_dq;
            r_dvs  <= i_dvs;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_dq    = r_dq;
    assign o_dvs   = r_dvs;
    assign o_side  = r_side;

endmodule

// File: rtl/axis_rect_ray_intersect.sv
// Top level of the ray against axis-aligned rectangle intersection pipeline.
//
// Rays arrive on the s_axis channel, one per transaction, and each produces
// exactly one result on the m_axis channel, in order. m_axis_tuser is the hit
// flag; on a miss every tdata field is zero.
// The rectangle is set through the cfg write channel, which is always ready;
// the user must write it only while no ray is in flight; the block does not enforce this.
// A new ray is accepted every cycle while the output is not stalled. The pipeline
// is the chain of one-bit division cells for t
// (FRAC_BITS + 33 cells) and the parallel u and v chains of 17 cells each for the texture
// coordinates, plus two setup, four arithmetic and one output stage.
// The whole pipeline advances only while the output register is empty or
// being taken, so a stalled receiver holds every stage and drops s_axis_tready.
// Reset clears all valid flags and loads the default unit square in the xy
// plane with material zero.
module axis_rect_ray_intersect
    import arri_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [2:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, range_min, range_max
    input  logic [255:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // hit_t, tex_u, tex_v, point_x, point_y, point_z, hit_material, zero pad
    output logic [175:0] m_axis_tdata,
    // is_hit
    output logic         m_axis_tuser
);

    localparam int NUM_W  = 33 + FRAC_BITS;
    localparam int RSIDE  = $bits(t_ray_side);
    localparam int HSIDE  = $bits(t_hit_side);
    localparam int PT_W   = 65;

    function automatic logic signed [31:0] sat32(input logic signed [PT_W-1:0] v);
        logic signed [31:0] res;
        res = v[31:0];
        if (v > PT_W'(signed'(32'sh7FFFFFFF))) begin
            res = 32'sh7FFFFFFF;
        end else if (v < PT_W'(signed'(32'sh80000000))) begin
            res = 32'sh80000000;
        end
        return res;
    endfunction

    t_axis              r_axis;
    logic signed [31:0] r_plane;
    logic signed [31:0] r_lo1;
    logic signed [31:0] r_hi1;
    logic signed [31:0] r_lo2;
    logic signed [31:0] r_hi2;
    logic [7:0]         r_mat;

    logic w_en;
    t_ray w_in_ray;

    assign o_cfg_ready   = 1'b1;
    assign w_en          = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = w_en;
    assign w_in_ray      = t_ray'(s_axis_tdata);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_axis  <= AXIS_XY;
            r_plane <= '0;
            r_lo1   <= '0;
            r_hi1   <= 32'sd1 <<< FRAC_BITS;
            r_lo2   <= '0;
            r_hi2   <= 32'sd1 <<< FRAC_BITS;
            r_mat   <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_AXIS_SELECT:  r_axis  <= t_axis'(i_cfg_data[1:0]);
                CFG_PLANE_OFFSET: r_plane <= i_cfg_data;
                CFG_FIRST_LOW:    r_lo1   <= i_cfg_data;
                CFG_FIRST_HIGH:   r_hi1   <= i_cfg_data;
                CFG_SECOND_LOW:   r_lo2   <= i_cfg_data;
                CFG_SECOND_HIGH:  r_hi2   <= i_cfg_data;
                CFG_MATERIAL_ID:  r_mat   <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Setup stage one: pick the normal axis.
    logic               r_p1_valid;
    logic signed [32:0] r_p1_diff;
    logic signed [31:0] r_p1_den;
    logic               r_p1_kill;
    t_ray               r_p1_ray;
    logic signed [31:0] n_p1_org;
    logic signed [31:0] n_p1_den;
    logic               n_p1_kill;

    always_comb begin
        n_p1_kill = 1'b0;
        case (r_axis)
            AXIS_XY: begin
                n_p1_org = w_in_ray.origin_z;
                n_p1_den = w_in_ray.dir_z;
            end
            AXIS_XZ: begin
                n_p1_org = w_in_ray.origin_y;
                n_p1_den = w_in_ray.dir_y;
            end
            AXIS_YZ: begin
                n_p1_org = w_in_ray.origin_x;
                n_p1_den = w_in_ray.dir_x;
            end
            default: begin
                n_p1_org  = '0;
                n_p1_den  = '0;
                n_p1_kill = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
        end else if (w_en) begin
            r_p1_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p1_diff <= 33'(r_plane) - 33'(n_p1_org);
            r_p1_den  <= n_p1_den;
            r_p1_kill <= n_p1_kill;
            r_p1_ray  <= w_in_ray;
        end
    end

    // Setup stage two: magnitudes and quotient sign.
    logic             r_p2_valid;
    logic [32:0]      r_p2_num;
    logic [DIV_W-1:0] r_p2_dvs;
    t_ray_side        r_p2_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p2_valid <= 1'b0;
        end else if (w_en) begin
            r_p2_valid <= r_p1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p2_num       <= r_p1_diff[32] ? 33'(-r_p1_diff) : 33'(r_p1_diff);
            r_p2_dvs       <= r_p1_den[31] ? 32'(-r_p1_den) : 32'(r_p1_den);
            r_p2_side.ray  <= r_p1_ray;
            r_p2_side.neg  <= r_p1_diff[32] ^ r_p1_den[31];
            r_p2_side.kill <= r_p1_kill || (r_p1_den == '0);
        end
    end

    // Division chain for t.
    logic             w_tv   [0:NUM_W];
    logic [DIV_W-1:0] w_trem [0:NUM_W];
    logic [NUM_W-1:0] w_tdq  [0:NUM_W];
    logic [DIV_W-1:0] w_tdvs [0:NUM_W];
    logic [RSIDE-1:0] w_tside[0:NUM_W];

    assign w_tv[0]    = r_p2_valid;
    assign w_trem[0]  = '0;
    assign w_tdq[0]   = {r_p2_num, {FRAC_BITS{1'b0}}};
    assign w_tdvs[0]  = r_p2_dvs;
    assign w_tside[0] = r_p2_side;

    for (genvar g = 0; g < NUM_W; g++) begin : g_tdiv
        arri_div_cell #(.DQ_W(NUM_W), .SIDE_W(RSIDE)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (w_en),
            .i_valid(w_tv[g]),
            .i_rem  (w_trem[g]),
            .i_dq   (w_tdq[g]),
            .i_dvs  (w_tdvs[g]),
            .i_side (w_tside[g]),
            .o_valid(w_tv[g+1]),
            .o_rem  (w_trem[g+1]),
            .o_dq   (w_tdq[g+1]),
            .o_dvs  (w_tdvs[g+1]),
            .o_side (w_tside[g+1])
        );
    end

    t_ray_side w_tend;
    assign w_tend = t_ray_side'(w_tside[NUM_W]);

    // Stage A: signed t.
    logic                   r_a_valid;
    logic signed [NUM_W:0]  r_a_t;
    t_ray_side              r_a_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_en) begin
            r_a_valid <= w_tv[NUM_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_t    <= w_tend.neg ? -$signed({1'b0, w_tdq[NUM_W]})
                                   : $signed({1'b0, w_tdq[NUM_W]});
            r_a_side <= w_tend;
        end
    end

    // Stage B: range test and products.
    logic               r_b_valid;
    logic               r_b_ok;
    logic signed [31:0] r_b_t;
    logic signed [63:0] r_b_prod [0:2];
    t_ray               r_b_ray;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (w_en) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b_ok <= !r_a_side.kill
                && (r_a_t >= (NUM_W+1)'(r_a_side.ray.range_min))
                && (r_a_t <= (NUM_W+1)'(r_a_side.ray.range_max));
            r_b_t       <= r_a_t[31:0];
            r_b_prod[0] <= $signed(r_a_t[31:0]) * r_a_side.ray.dir_x;
            r_b_prod[1] <= $signed(r_a_t[31:0]) * r_a_side.ray.dir_y;
            r_b_prod[2] <= $signed(r_a_t[31:0]) * r_a_side.ray.dir_z;
            r_b_ray     <= r_a_side.ray;
        end
    end

    // Stage C: hit point.
    logic                  r_c_valid;
    logic                  r_c_ok;
    logic signed [31:0]    r_c_t;
    logic signed [PT_W-1:0] r_c_pt [0:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (w_en) begin
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c_ok    <= r_b_ok;
            r_c_t     <= r_b_t;
            r_c_pt[0] <= PT_W'(r_b_ray.origin_x) + PT_W'(r_b_prod[0] >>> FRAC_BITS);
            r_c_pt[1] <= PT_W'(r_b_ray.origin_y) + PT_W'(r_b_prod[1] >>> FRAC_BITS);
            r_c_pt[2] <= PT_W'(r_b_ray.origin_z) + PT_W'(r_b_prod[2] >>> FRAC_BITS);
        end
    end

    // Stage D: bound tests and texture operands.
    logic signed [PT_W-1:0] w_c1;
    logic signed [PT_W-1:0] w_c2;
    logic signed [PT_W-1:0] w_d1;
    logic signed [PT_W-1:0] w_d2;
    logic signed [32:0]     w_s1;
    logic signed [32:0]     w_s2;
    logic                   w_in;

    always_comb begin
        case (r_axis)
            AXIS_XZ: begin
                w_c1 = r_c_pt[0];
                w_c2 = r_c_pt[2];
            end
            AXIS_YZ: begin
                w_c1 = r_c_pt[1];
                w_c2 = r_c_pt[2];
            end
            default: begin
                w_c1 = r_c_pt[0];
                w_c2 = r_c_pt[1];
            end
        endcase
        w_in = (w_c1 >= PT_W'(r_lo1)) && (w_c1 <= PT_W'(r_hi1))
            && (w_c2 >= PT_W'(r_lo2)) && (w_c2 <= PT_W'(r_hi2));
        w_d1 = w_c1 - PT_W'(r_lo1);
        w_d2 = w_c2 - PT_W'(r_lo2);
        w_s1 = 33'(r_hi1) - 33'(r_lo1);
        w_s2 = 33'(r_hi2) - 33'(r_lo2);
    end

    logic             r_d_valid;
    logic [DIV_W-1:0] r_d_diff1;
    logic [DIV_W-1:0] r_d_diff2;
    logic [DIV_W-1:0] r_d_span1;
    logic [DIV_W-1:0] r_d_span2;
    t_hit_side        r_d_uside;
    logic             r_d_vzero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
        end else if (w_en) begin
            r_d_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d_diff1           <= w_d1[DIV_W-1:0];
            r_d_diff2           <= w_d2[DIV_W-1:0];
            r_d_span1           <= w_s1[DIV_W-1:0];
            r_d_span2           <= w_s2[DIV_W-1:0];
            r_d_uside.hit       <= r_c_ok && w_in;
            r_d_uside.zero_span <= (w_s1 == '0);
            r_d_uside.t         <= r_c_t;
            r_d_uside.point_x   <= sat32(r_c_pt[0]);
            r_d_uside.point_y   <= sat32(r_c_pt[1]);
            r_d_uside.point_z   <= sat32(r_c_pt[2]);
            r_d_vzero           <= (w_s2 == '0);
        end
    end

    // Texture division chains, u and v side by side.
    logic             w_uv   [0:TEX_W];
    logic [DIV_W-1:0] w_urem [0:TEX_W];
    logic [TEX_W-1:0] w_udq  [0:TEX_W];
    logic [DIV_W-1:0] w_udvs [0:TEX_W];
    logic [HSIDE-1:0] w_uside[0:TEX_W];
    logic             w_vv   [0:TEX_W];
    logic [DIV_W-1:0] w_vrem [0:TEX_W];
    logic [TEX_W-1:0] w_vdq  [0:TEX_W];
    logic [DIV_W-1:0] w_vdvs [0:TEX_W];
    logic [0:0]       w_vside[0:TEX_W];

    assign w_uv[0]    = r_d_valid;
    assign w_urem[0]  = {1'b0, r_d_diff1[DIV_W-1:1]};
    assign w_udq[0]   = {r_d_diff1[0], {TEX_BITS{1'b0}}};
    assign w_udvs[0]  = r_d_span1;
    assign w_uside[0] = r_d_uside;
    assign w_vv[0]    = r_d_valid;
    assign w_vrem[0]  = {1'b0, r_d_diff2[DIV_W-1:1]};
    assign w_vdq[0]   = {r_d_diff2[0], {TEX_BITS{1'b0}}};
    assign w_vdvs[0]  = r_d_span2;
    assign w_vside[0] = r_d_vzero;

    for (genvar g = 0; g < TEX_W; g++) begin : g_tex
        arri_div_cell #(.DQ_W(TEX_W), .SIDE_W(HSIDE)) u_ucell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (w_en),
            .i_valid(w_uv[g]),
            .i_rem  (w_urem[g]),
            .i_dq   (w_udq[g]),
            .i_dvs  (w_udvs[g]),
            .i_side (w_uside[g]),
            .o_valid(w_uv[g+1]),
            .o_rem  (w_urem[g+1]),
            .o_dq   (w_udq[g+1]),
            .o_dvs  (w_udvs[g+1]),
            .o_side (w_uside[g+1])
        );
        arri_div_cell #(.DQ_W(TEX_W), .SIDE_W(1)) u_vcell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (w_en),
            .i_valid(w_vv[g]),
            .i_rem  (w_vrem[g]),
            .i_dq   (w_vdq[g]),
            .i_dvs  (w_vdvs[g]),
            .i_side (w_vside[g]),
            .o_valid(w_vv[g+1]),
            .o_rem  (w_vrem[g+1]),
            .o_dq   (w_vdq[g+1]),
            .o_dvs  (w_vdvs[g+1]),
            .o_side (w_vside[g+1])
        );
    end

    t_hit_side w_hend;
    assign w_hend = t_hit_side'(w_uside[TEX_W]);

    // Output register.
    logic         r_out_valid;
    logic [175:0] r_out_data;
    logic         r_out_hit;
    logic [TEX_W-1:0] w_u;
    logic [TEX_W-1:0] w_v;

    assign w_u = w_hend.zero_span ? '0 : w_udq[TEX_W];
    assign w_v = w_vside[TEX_W][0] ? '0 : w_vdq[TEX_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_uv[TEX_W] && w_vv[TEX_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_hit <= w_hend.hit;
            if (w_hend.hit) begin
                r_out_data <= {6'd0, r_mat, w_hend.point_z, w_hend.point_y,
                               w_hend.point_x, w_v, w_u, w_hend.t};
            end else begin
                r_out_data <= '0;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_hit;

endmodule

// File: rtl/arri_checker.sv
// Port-level checks for the intersection block and their binding.
module arri_port_checks (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [175:0] m_axis_tdata,
    input logic         m_axis_tuser
);

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("Stalled result changed.");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
        else $error("Miss carries nonzero data.");

    a_tex_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[48:32] <= 17'd65536
            && m_axis_tdata[65:49] <= 17'd65536)
        else $error("Texture coordinate out of range.");

    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("Input ready does not follow output space.");

    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("Result valid after reset.");

endmodule

bind axis_rect_ray_intersect arri_port_checks u_arri_port_checks (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
);
